[rtl/twrtc_pkg.sv]
`default_nettype none
package twrtc_pkg;

  // Request kinds
  localparam logic [1:0] REQ_RAW_WR = 2'd0;
  localparam logic [1:0] REQ_RAW_RD = 2'd1;
  localparam logic [1:0] REQ_BCD_WR = 2'd2;
  localparam logic [1:0] REQ_BCD_RD = 2'd3;

  // Schedule points
  localparam logic [5:0] WR_END     = 6'd48;
  localparam logic [5:0] RD_CMD_END = 6'd24;
  localparam logic [5:0] RD_END     = 6'd47;

  localparam int QUEUE_DEPTH = 2;

  // Classified tick handed from front to back
  typedef struct packed {
    logic       start;
    logic [1:0] mode;
    logic [7:0] cmd;   // read bit already forced
    logic [7:0] wval;  // already BCD-coded for BCD writes
    logic       io_in;
  } item_t;

  // Line levels
  typedef struct packed {
    logic drv;
    logic io;
    logic clk;
    logic ce;
  } pins_t;

  // One result beat
  typedef struct packed {
    logic [7:0] read_value;
    logic       done;
    logic       busy;
    pins_t      pins;
  } result_t;

endpackage
`default_nettype wire

[rtl/twrtc_front.sv]
`default_nettype none
module twrtc_front (
  input  wire logic            start_req_i,
  input  wire logic [1:0]      req_type_i,
  input  wire logic [7:0]      command_i,
  input  wire logic [7:0]      write_value_i,
  input  wire logic            io_in_i,
  output twrtc_pkg::item_t     item_o
);
  import twrtc_pkg::*;

  logic [15:0] prod;
  logic [4:0]  tens;
  logic [7:0]  ones;
  logic [7:0]  bcd;

  // Divide by ten through a reciprocal; exact for all 8-bit values
  always_comb begin
    prod = 16'(write_value_i) * 16'd205;
    tens = prod[15:11];
    ones = write_value_i - 8'({tens, 3'b000} + {2'b00, tens, 1'b0});
    bcd  = {tens[3:0], ones[3:0]};
  end

  always_comb begin
    item_o.start = start_req_i;
    item_o.mode  = req_type_i;
    item_o.cmd   = req_type_i[0] ? (command_i | 8'h01) : command_i;
    item_o.wval  = (req_type_i == REQ_BCD_WR) ? bcd : write_value_i;
    item_o.io_in = io_in_i;
  end

endmodule
`default_nettype wire

[rtl/twrtc_queue.sv]
`default_nettype none
module twrtc_queue (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire twrtc_pkg::item_t push_item_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  valid_o,
  output twrtc_pkg::item_t      head_o
);
  import twrtc_pkg::*;

  localparam int PtrW = $clog2(QUEUE_DEPTH);

  item_t            mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0]  wptr_q, rptr_q;
  logic [PtrW:0]    count_q;

  assign full_o  = (count_q == (PtrW+1)'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      mem_q[wptr_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i && !full_o) wptr_q <= wptr_q + 1'b1;
      if (pop_i && valid_o)  rptr_q <= rptr_q + 1'b1;
      count_q <= count_q + (PtrW+1)'(push_i && !full_o) - (PtrW+1)'(pop_i && valid_o);
    end
  end

endmodule
`default_nettype wire

[rtl/twrtc_back.sv]
`default_nettype none
module twrtc_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             valid_i,
  input  wire twrtc_pkg::item_t item_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  output twrtc_pkg::result_t    out_o,
  input  wire logic             out_ready_i
);
  import twrtc_pkg::*;

  // p / 3 for a 6-bit p, as {quotient, remainder}
  function automatic logic [6:0] div3(input logic [5:0] p);
    logic [13:0] pr;
    logic [4:0]  qt;
    logic [5:0]  rm;
    pr = 14'(p) * 14'd171;
    qt = pr[13:9];
    rm = p - 6'({qt, 1'b0} + {1'b0, qt});
    return {qt, rm[1:0]};
  endfunction

  logic        active_q, active_d;
  logic [1:0]  mode_q, mode_d;
  logic [15:0] shift_q, shift_d;
  logic [7:0]  cap_q, cap_d;
  logic [5:0]  phase_q, phase_d;
  pins_t       pins_q, pins_d;
  logic        out_valid_q;
  result_t     out_q, out_d;

  logic        rd, fin;
  logic [6:0]  dv, dq;
  logic [5:0]  qoff;
  logic [2:0]  k;
  logic [3:0]  bsel;
  logic [7:0]  dec;

  assign pop_o       = valid_i && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  always_comb begin
    active_d = active_q;
    mode_d   = mode_q;
    shift_d  = shift_q;
    cap_d    = cap_q;
    phase_d  = phase_q;
    pins_d   = pins_q;
    out_d    = '0;
    rd       = 1'b0;
    fin      = 1'b0;
    dv       = '0;
    dq       = '0;
    qoff     = '0;
    k        = '0;
    bsel     = '0;
    dec      = '0;

    // Latch a new transfer when idle
    if (!active_q && item_i.start) begin
      mode_d   = item_i.mode;
      shift_d  = {item_i.wval, item_i.cmd};
      cap_d    = '0;
      phase_d  = '0;
      active_d = 1'b1;
    end

    if (active_d) begin
      rd  = mode_d[0];
      fin = rd ? (phase_d >= RD_END) : (phase_d >= WR_END);
      if (fin) begin
        pins_d   = '{drv: 1'b1, io: 1'b0, clk: 1'b0, ce: 1'b0};
        out_d.done = 1'b1;
        if (rd) begin
          dec = 8'({cap_d[7:4], 3'b000}) + 8'({cap_d[7:4], 1'b0}) + 8'(cap_d[3:0]);
          out_d.read_value = (mode_d == REQ_BCD_RD) ? dec : cap_d;
        end
        active_d = 1'b0;
        phase_d  = '0;
      end else begin
        out_d.busy = 1'b1;
        pins_d.ce  = 1'b1;
        if (!rd || phase_d < RD_CMD_END) begin
          dv         = div3(phase_d);
          bsel       = dv[5:2];
          pins_d.io  = shift_d[bsel];
          pins_d.drv = 1'b1;
          pins_d.clk = (dv[1:0] == 2'd1);
        end else begin
          pins_d.io  = 1'b0;
          pins_d.drv = 1'b0;
          pins_d.clk = 1'b0;
          if (phase_d == RD_CMD_END + 6'd1) begin
            cap_d[0] = cap_d[0] | item_i.io_in;
          end else if (phase_d > RD_CMD_END + 6'd1) begin
            qoff = phase_d - (RD_CMD_END + 6'd2);
            dq   = div3(qoff);
            k    = dq[4:2] + 3'd1;
            if (dq[1:0] == 2'd0) begin
              pins_d.clk = 1'b1;
            end else if (dq[1:0] == 2'd2) begin
              cap_d[k] = cap_d[k] | item_i.io_in;
            end
          end
        end
        phase_d = phase_d + 6'd1;
      end
    end
    out_d.pins = pins_d;
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      mode_q      <= '0;
      shift_q     <= '0;
      cap_q       <= '0;
      phase_q     <= '0;
      pins_q      <= '{drv: 1'b1, io: 1'b0, clk: 1'b0, ce: 1'b0};
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        active_q <= active_d;
        mode_q   <= mode_d;
        shift_q  <= shift_d;
        cap_q    <= cap_d;
        phase_q  <= phase_d;
        pins_q   <= pins_d;
      end
      if (pop_o)            out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

endmodule
`default_nettype wire

[rtl/three_wire_rtc_serial_master_unit.sv]
`default_nettype none
// Path: an accepted tick beat is held in the tick queue, then in the output register,
//   before it leaves as a result beat.
// Throughput: one tick per cycle unless the output register is full and not being taken.
// Reset (rst_ni low, async): idle, chip enable and clock low, data line driven zero,
//   tick queue and output register emptied.
module three_wire_rtc_serial_master_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Tick stream in
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [23:0] s_axis_tdata_i,  // [7:0] command, [15:8] write_value, [16] io_in
  input  wire logic [2:0]  s_axis_tuser_i,  // [0] start_req, [2:1] req_type
  // Line levels and status out
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [15:0]      m_axis_tdata_o,  // [0] chip_enable, [1] serial_clock, [2] io_out,
                                            // [3] io_drive, [4] busy_res, [12:5] read_value
  output logic             m_axis_tlast_o   // done_res: final beat of a transfer
);
  import twrtc_pkg::*;

  item_t   front_item, head_item;
  logic    q_full, q_valid, q_pop;
  result_t res;

  // Front: classify the tick, force the read bit, BCD-code write data
  twrtc_front u_front (
    .start_req_i   (s_axis_tuser_i[0]),
    .req_type_i    (s_axis_tuser_i[2:1]),
    .command_i     (s_axis_tdata_i[7:0]),
    .write_value_i (s_axis_tdata_i[15:8]),
    .io_in_i       (s_axis_tdata_i[16]),
    .item_o        (front_item)
  );

  // Hold classified ticks so either side can stall alone
  twrtc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s_axis_tvalid_i),
    .push_item_i (front_item),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .head_o      (head_item)
  );

  assign s_axis_tready_o = !q_full;

  // Back: advance the serial schedule one tick per popped beat
  twrtc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (q_valid),
    .item_i      (head_item),
    .pop_o       (q_pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_o       (res),
    .out_ready_i (m_axis_tready_i)
  );

  assign m_axis_tdata_o = {3'b000, res.read_value, res.busy,
                           res.pins.drv, res.pins.io, res.pins.clk, res.pins.ce};
  assign m_axis_tlast_o = res.done;

endmodule
`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 1ps

// Stream-level check of the three-wire RTC serial master: every accepted tick beat
// yields one line-level beat, predicted here and compared against the block output.
module tb;
  import twrtc_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_HOLD   = 300;   // receiver hold-off, long enough to back up the tick queue
  localparam int HOLD_AT     = 400;   // output beat after which the long hold-off starts
  localparam int RANDOM_TICKS = 460;

  // One tick of the serial waveform as offered on the input stream
  typedef struct {
    bit         start;
    logic [1:0] kind;
    logic [7:0] cmd;
    logic [7:0] wval;
    bit         io_in;
    int         gap;    // idle cycles the sender spends before offering this beat
    bit         drain;  // hold this beat until every predicted beat has come back
  } rtc_tick_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic [23:0] s_tdata = '0;   // [7:0] command, [15:8] write_value, [16] io_in
  logic [2:0]  s_tuser = '0;   // [0] start_req, [2:1] req_type
  logic        m_tready = 1'b0;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [15:0] m_axis_tdata_o;  // [0] ce, [1] sclk, [2] io_out, [3] io_drive, [4] busy,
                                // [12:5] read_value
  logic        m_axis_tlast_o;  // done

  three_wire_rtc_serial_master_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  rtc_tick_t pending_ticks[$];
  result_t   expected_lines[$];
  int        mismatches = 0;
  int        cycle_count = 0;

  // ---------------------------------------------------------------------------
  // Serial engine shadow state
  // ---------------------------------------------------------------------------
  logic [5:0]  ser_phase = '0;
  logic [15:0] ser_shift = '0;   // data byte high, command byte low
  logic [7:0]  ser_capture = '0;
  logic [1:0]  ser_mode = REQ_RAW_WR;
  bit          ser_active = 1'b0;
  pins_t       ser_pins = '{drv: 1'b1, io: 1'b0, clk: 1'b0, ce: 1'b0};

  // Advance the shadow engine by one tick and return the line levels it produces.
  function automatic result_t predict_line_levels(input rtc_tick_t t);
    result_t    r;
    logic [7:0] c;
    int         v;
    int         q;
    bit         rd;
    bit         fin;
    r = '0;
    r.pins = ser_pins;
    if (!ser_active && t.start) begin
      ser_mode = t.kind;
      c = t.cmd;
      if (ser_mode[0])
        c[0] = 1'b1;              // reads always carry the read bit
      v = t.wval;
      if (ser_mode == REQ_BCD_WR)
        v = (v / 10) * 16 + v % 10;  // wraps for inputs above 159
      ser_shift = {8'(v), c};
      ser_capture = '0;
      ser_phase = '0;
      ser_active = 1'b1;
    end
    if (ser_active) begin
      rd = ser_mode[0];
      fin = rd ? (ser_phase >= RD_END) : (ser_phase >= WR_END);
      if (fin) begin
        // final tick: chip enable drops, line driven low, nothing accepted
        ser_pins = '{drv: 1'b1, io: 1'b0, clk: 1'b0, ce: 1'b0};
        r.done = 1'b1;
        if (rd)
          r.read_value = (ser_mode == REQ_BCD_RD) ?
                         8'(int'(ser_capture[7:4]) * 10 + int'(ser_capture[3:0])) :
                         ser_capture;
        ser_active = 1'b0;
        ser_phase = '0;
      end else begin
        r.busy = 1'b1;
        ser_pins.ce = 1'b1;
        if (!rd || ser_phase < RD_CMD_END) begin
          // three ticks per bit: set data, clock high, clock low
          ser_pins.io = ser_shift[ser_phase / 3];
          ser_pins.drv = 1'b1;
          ser_pins.clk = (ser_phase % 3 == 1);
        end else begin
          ser_pins.io = 1'b0;
          ser_pins.drv = 1'b0;
          ser_pins.clk = 1'b0;
          if (ser_phase == RD_CMD_END + 6'd1) begin
            ser_capture[0] = ser_capture[0] | t.io_in;
          end else if (ser_phase > RD_CMD_END + 6'd1) begin
            q = int'(ser_phase) - int'(RD_CMD_END) - 2;
            if (q % 3 == 0)
              ser_pins.clk = 1'b1;
            else if (q % 3 == 2)
              ser_capture[(q / 3 + 1) % 8] = ser_capture[(q / 3 + 1) % 8] | t.io_in;
          end
        end
        ser_phase = ser_phase + 6'd1;
      end
      r.pins = ser_pins;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------------
  int gap_max = 0;
  bit drain_next = 1'b0;
  int n_ticks = 0;

  task automatic push_tick(input bit start, input logic [1:0] kind, input logic [7:0] cmd,
                           input logic [7:0] wval, input bit io);
    rtc_tick_t t;
    t.start = start;
    t.kind = kind;
    t.cmd = cmd;
    t.wval = wval;
    t.io_in = io;
    t.gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
    t.drain = drain_next;
    drain_next = 1'b0;
    pending_ticks.push_back(t);
    n_ticks++;
  endtask

  // Queue one full transfer. On reads, put the bits of rd_byte on the sampled ticks.
  // A noisy transfer also raises start while busy and on its final tick.
  task automatic run_transfer(input logic [1:0] kind, input logic [7:0] cmd,
                              input logic [7:0] wval, input logic [7:0] rd_byte,
                              input bit noisy);
    int last;
    int p;
    bit io;
    last = kind[0] ? int'(RD_END) : int'(WR_END);
    push_tick(1'b1, kind, cmd, wval, 1'($urandom_range(0, 1)));
    for (p = 1; p <= last; p++) begin
      io = 1'($urandom_range(0, 1));
      if (kind[0] && p >= int'(RD_CMD_END) + 1 && (p - int'(RD_CMD_END) - 1) % 3 == 0)
        io = rd_byte[(p - int'(RD_CMD_END) - 1) / 3];
      if (noisy && (p == last || $urandom_range(0, 3) == 0))
        push_tick(1'b1, 2'($urandom_range(0, 3)), 8'($urandom), 8'($urandom), io);
      else
        push_tick(1'b0, 2'($urandom_range(0, 3)), 8'($urandom), 8'($urandom), io);
    end
  endtask

  // Idle ticks; wild ones carry a random start and may kick off a transfer out of step.
  task automatic idle_ticks(input int n, input bit wild);
    int i;
    for (i = 0; i < n; i++)
      push_tick(wild ? 1'($urandom_range(0, 1)) : 1'b0, 2'($urandom_range(0, 3)),
                8'($urandom), 8'($urandom), 1'($urandom_range(0, 1)));
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offer queued ticks, honoring per-beat gaps and drain requests
  // ---------------------------------------------------------------------------
  rtc_tick_t on_wire;
  int        tx_spent = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
      tx_spent = 0;
    end else begin
      if (s_tvalid && s_axis_tready_o)
        expected_lines.push_back(predict_line_levels(on_wire));
      if (!s_tvalid || s_axis_tready_o) begin
        if (pending_ticks.size() == 0) begin
          s_tvalid <= 1'b0;
        end else if (tx_spent < pending_ticks[0].gap) begin
          tx_spent++;
          s_tvalid <= 1'b0;
        end else if (pending_ticks[0].drain && expected_lines.size() != 0) begin
          s_tvalid <= 1'b0;     // pause until the output side has caught up
        end else begin
          on_wire = pending_ticks.pop_front();
          tx_spent = 0;
          s_tdata <= {7'b0, on_wire.io_in, on_wire.wval, on_wire.cmd};
          s_tuser <= {on_wire.kind, on_wire.start};
          s_tvalid <= 1'b1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check each line-level beat, then draw the next receiver stall
  // ---------------------------------------------------------------------------
  result_t got;
  result_t want;
  int      sink_hold = 0;
  int      beats_out = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tready <= 1'b0;
      sink_hold = 0;
    end else begin
      if (m_axis_tvalid_o && m_tready) begin
        got.pins = pins_t'(m_axis_tdata_o[3:0]);
        got.busy = m_axis_tdata_o[4];
        got.done = m_axis_tlast_o;
        got.read_value = m_axis_tdata_o[12:5];
        if (expected_lines.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("beat %0d: output beat with nothing predicted (tdata %04h)",
                     beats_out, m_axis_tdata_o);
        end else begin
          want = expected_lines.pop_front();
          if (got.pins.ce !== want.pins.ce || got.pins.clk !== want.pins.clk ||
              got.pins.io !== want.pins.io || got.pins.drv !== want.pins.drv ||
              got.busy !== want.busy || got.done !== want.done ||
              got.read_value !== want.read_value) begin
            mismatches++;
            if (mismatches <= 10)
              $display("beat %0d: want ce %0b sclk %0b io %0b drv %0b busy %0b done %0b",
                       beats_out,
                       want.pins.ce, want.pins.clk, want.pins.io, want.pins.drv,
                       want.busy, want.done,
                       " rd %02h / got ce %0b sclk %0b io %0b drv %0b busy %0b done %0b",
                       want.read_value,
                       got.pins.ce, got.pins.clk, got.pins.io, got.pins.drv,
                       got.busy, got.done,
                       " rd %02h", got.read_value);
          end
        end
        beats_out++;
        // one long hold-off backs the block up; otherwise alternate calm and stalled stretches
        if (beats_out == HOLD_AT)
          sink_hold = LONG_HOLD;
        else if ((beats_out / 128) % 3 == 0)
          sink_hold = 0;
        else
          sink_hold = $urandom_range(0, 12);
      end
      if (sink_hold != 0) begin
        sink_hold--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[three_wire_rtc_serial_master_unit] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: build all ticks, release reset, wait for the output to drain
  // ---------------------------------------------------------------------------
  int directed_end;
  int sel;

  initial begin
    // directed: idle after reset, extremes of every request kind, start while busy
    // and on the final tick, back-to-back transfers
    gap_max = 0;
    idle_ticks(2, 1'b0);
    run_transfer(REQ_RAW_WR, 8'h00, 8'hFF, 8'h00, 1'b0);
    run_transfer(REQ_RAW_WR, 8'hFF, 8'h00, 8'h00, 1'b1);
    run_transfer(REQ_RAW_RD, 8'h80, 8'h5A, 8'hFF, 1'b0);
    gap_max = 12;
    run_transfer(REQ_RAW_RD, 8'hFE, 8'hA5, 8'h00, 1'b1);
    run_transfer(REQ_BCD_WR, 8'h8E, 8'd99, 8'h00, 1'b0);
    run_transfer(REQ_BCD_WR, 8'h8E, 8'd255, 8'h00, 1'b0);
    gap_max = 3;
    run_transfer(REQ_BCD_WR, 8'h01, 8'd0, 8'h00, 1'b0);
    run_transfer(REQ_BCD_RD, 8'h81, 8'h00, 8'h99, 1'b0);
    run_transfer(REQ_BCD_RD, 8'h00, 8'h00, 8'hFF, 1'b1);
    run_transfer(REQ_BCD_RD, 8'hFF, 8'hFF, 8'h00, 1'b0);
    idle_ticks(3, 1'b0);
    directed_end = n_ticks;

    // random: mostly well-formed transfers, some idle and wild ticks in between
    drain_next = 1'b1;
    while (n_ticks < directed_end + RANDOM_TICKS) begin
      case ($urandom_range(0, 2))
        0: gap_max = 0;
        1: gap_max = 12;
        default: gap_max = 3;
      endcase
      sel = $urandom_range(0, 19);
      if (sel < 16)
        run_transfer(2'($urandom_range(0, 3)), 8'($urandom), 8'($urandom), 8'($urandom),
                     1'($urandom_range(0, 1)));
      else if (sel < 18)
        idle_ticks($urandom_range(1, 4), 1'b0);
      else
        idle_ticks($urandom_range(1, 6), 1'b1);
      if ($urandom_range(0, 9) == 0)
        drain_next = 1'b1;
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    do
      @(negedge clk_i);
    while (pending_ticks.size() != 0 || s_tvalid || expected_lines.size() != 0);
    repeat (8) @(negedge clk_i);   // room for a stray beat past the tick queue and output register

    if (mismatches == 0 && expected_lines.size() == 0)
      $display("[three_wire_rtc_serial_master_unit] OK");
    else
      $display("[three_wire_rtc_serial_master_unit] ERROR");
    $finish;
  end

endmodule
